// ===== sv/u8l1s_pkg.sv =====
// ----------------------------------------------------------------------------
// u8l1s_pkg
// Shared types, constants and the Latin-1 transliteration table for the
// UTF-8 to ASCII accent stripper.
// ----------------------------------------------------------------------------
package u8l1s_pkg;

  // Widths of the stream fields
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned ACCUM_W = 31;
  localparam int unsigned LEFT_W  = 3;

  // Fallback character after reset: '?'
  localparam logic [CHAR_W-1:0] FALLBACK_RESET = 7'd63;

  // Latin-1 0xC0..0xFF, first character at the top of the vector
  localparam logic [8*64-1:0] LATIN1_TABLE =
    "AAAAAAECEEEEIIIIDNOOOOOxOUUUUYPsaaaaaaeceeeeiiiidnooooo/ouuuuypy";

  // Latin-1 codes that expand to two characters (low six bits)
  localparam logic [5:0] IDX_AE_UC    = 6'h06;  // 0xC6
  localparam logic [5:0] IDX_ETH_UC   = 6'h10;  // 0xD0
  localparam logic [5:0] IDX_THORN_UC = 6'h1E;  // 0xDE
  localparam logic [5:0] IDX_SHARP_S  = 6'h1F;  // 0xDF
  localparam logic [5:0] IDX_AE_LC    = 6'h26;  // 0xE6
  localparam logic [5:0] IDX_ETH_LC   = 6'h30;  // 0xF0
  localparam logic [5:0] IDX_THORN_LC = 6'h3E;  // 0xFE

  // One mapped code point: one or two characters
  typedef struct packed {
    logic [CHAR_W-1:0] c0;
    logic [CHAR_W-1:0] c1;
    logic              two;
  } map_t;

  // One pending result item
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              done;
  } res_t;

  // Map the low six bits of a code point in 0xC0..0xFF
  function automatic map_t map_latin1(input logic [5:0] idx);
    map_t m;
    logic [7:0] tbl_byte;
    tbl_byte = LATIN1_TABLE[8*(63 - int'(idx)) +: 8];
    m.c0  = tbl_byte[CHAR_W-1:0];
    m.c1  = tbl_byte[CHAR_W-1:0];
    m.two = 1'b0;
    unique case (idx)
      IDX_AE_UC: begin
        m.c0 = 7'(int'("A")); m.c1 = 7'(int'("E")); m.two = 1'b1;
      end
      IDX_ETH_UC, IDX_THORN_UC: begin
        m.c0 = 7'(int'("T")); m.c1 = 7'(int'("H")); m.two = 1'b1;
      end
      IDX_SHARP_S: begin
        m.c0 = 7'(int'("s")); m.c1 = 7'(int'("s")); m.two = 1'b1;
      end
      IDX_AE_LC: begin
        m.c0 = 7'(int'("a")); m.c1 = 7'(int'("e")); m.two = 1'b1;
      end
      IDX_ETH_LC, IDX_THORN_LC: begin
        m.c0 = 7'(int'("t")); m.c1 = 7'(int'("h")); m.two = 1'b1;
      end
      default: begin
        m.two = 1'b0;
      end
    endcase
    return m;
  endfunction

endpackage

// ===== sv/utf8_latin1_accent_stripper_top.sv =====
// ----------------------------------------------------------------------------
// utf8_latin1_accent_stripper_top
// Decodes a UTF-8 byte stream (six-byte form) and strips it to ASCII.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the result register has room and gives
// one or two ASCII characters for each completed code point: ASCII passes
// through, Latin-1 letters lose their accents (AE, ae, eth, thorn and
// sharp s become two letters), anything else becomes the programmable
// fallback character. Following bytes are not checked, and a text that
// ends inside a sequence emits the partial value. A byte goes from the
// input register through decode and mapping into a two-entry result
// register, which drives the output. Sustained rate is one byte per cycle
// while every character is taken; a two-character code point fills both
// result entries, which the multi-byte sequence feeding it always covers.
// ----------------------------------------------------------------------------
module utf8_latin1_accent_stripper_top
  import u8l1s_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input bytes
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] in_byte
  input  logic              in_tlast,   // end_of_text
  // output characters
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [6:0] out_char, [7] zero
  output logic              out_tlast,  // last_of_run
  output logic              out_tuser,  // text_done
  // fallback character register
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CHAR_W-1:0] cfg_data
);

  // input register
  logic               s1_valid_r;
  logic [BYTE_W-1:0]  s1_byte_r;
  logic               s1_eot_r;
  // decode state
  logic [ACCUM_W-1:0] accum_r, accum_nxt;
  logic [LEFT_W-1:0]  left_r, left_nxt;
  logic [CHAR_W-1:0]  fallback_r;
  // result register
  res_t               slot0_r, slot1_r, slot0_nxt, slot1_nxt;
  logic [1:0]         cnt_r, cnt_nxt;

  logic               emit;
  logic               s1_adv;
  logic               res_free;
  logic               out_fire;
  logic               is_ascii, is_latin;
  map_t               lat_map;
  map_t               res_map;
  logic [ACCUM_W-1:0] step_accum;
  logic [LEFT_W-1:0]  step_left;

  assign cfg_ready = 1'b1;
  assign out_fire  = out_tvalid && out_tready;
  // room for the new characters once this cycle's transfer has left
  assign res_free  = (cnt_r == 2'd0)
                  || ((cnt_r == 2'd1) && (out_fire || !res_map.two))
                  || ((cnt_r == 2'd2) && out_fire && !res_map.two);
  assign s1_adv    = s1_valid_r && (!emit || res_free);
  assign in_tready = !s1_valid_r || s1_adv;

  // fallback register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r <= FALLBACK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fallback_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_eot_r  <= in_tlast;
    end
  end

  // sequence decode: following byte or lead byte
  always_comb begin
    logic [BYTE_W-1:0] mask;
    logic [LEFT_W-1:0] extra;
    mask  = 8'hFF;
    extra = 3'd0;
    priority if (s1_byte_r[7:2] == 6'h3F) begin
      extra = 3'd5; mask = 8'h01;
    end else if (s1_byte_r[7:3] == 5'h1F) begin
      extra = 3'd4; mask = 8'h03;
    end else if (s1_byte_r[7:4] == 4'hF) begin
      extra = 3'd3; mask = 8'h07;
    end else if (s1_byte_r[7:5] == 3'h7) begin
      extra = 3'd2; mask = 8'h0F;
    end else if (s1_byte_r[7:6] == 2'h3) begin
      extra = 3'd1; mask = 8'h1F;
    end else begin
      extra = 3'd0; mask = 8'hFF;
    end
    if (left_r != 3'd0) begin
      step_accum = {accum_r[ACCUM_W-7:0], s1_byte_r[5:0]};
      step_left  = left_r - 3'd1;
    end else begin
      step_accum = {23'd0, s1_byte_r & mask};
      step_left  = extra;
    end
  end

  assign emit = (step_left == 3'd0) || s1_eot_r;

  // code point to characters
  assign is_ascii = (step_accum[ACCUM_W-1:7] == '0);
  assign is_latin = (step_accum[ACCUM_W-1:8] == '0) && (step_accum[7:6] == 2'b11);
  assign lat_map  = map_latin1(step_accum[5:0]);

  always_comb begin
    res_map.c0  = fallback_r;
    res_map.c1  = fallback_r;
    res_map.two = 1'b0;
    if (is_ascii) begin
      res_map.c0 = step_accum[CHAR_W-1:0];
    end else if (is_latin) begin
      res_map = lat_map;
    end
  end

  // decode state update
  always_comb begin
    accum_nxt = accum_r;
    left_nxt  = left_r;
    if (s1_adv) begin
      if (emit) begin
        accum_nxt = '0;
        left_nxt  = '0;
      end else begin
        accum_nxt = step_accum;
        left_nxt  = step_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      left_r  <= '0;
    end else begin
      accum_r <= accum_nxt;
      left_r  <= left_nxt;
    end
  end

  // result register: slot0 is shown, slot1 waits behind it
  always_comb begin
    res_t       first_res;
    res_t       second_res;
    logic [1:0] held;
    first_res.ch    = res_map.c0;
    first_res.last  = !res_map.two;
    first_res.done  = !res_map.two && s1_eot_r;
    second_res.ch   = res_map.c1;
    second_res.last = 1'b1;
    second_res.done = s1_eot_r;
    // the transferred entry leaves first
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    held      = cnt_r;
    if (out_fire) begin
      slot0_nxt = slot1_r;
      held      = cnt_r - 2'd1;
    end
    cnt_nxt = held;
    // new characters go behind whatever is left
    if (s1_adv && emit) begin
      if (held == 2'd0) begin
        slot0_nxt = first_res;
        slot1_nxt = second_res;
      end else begin
        slot1_nxt = first_res;
      end
      cnt_nxt = held + (res_map.two ? 2'd2 : 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {1'b0, slot0_r.ch};
  assign out_tlast  = slot0_r.last;
  assign out_tuser  = slot0_r.done;

`ifndef SYNTHESIS
  // at most five following bytes are ever outstanding
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= 3'd5)
    else $error("following byte count out of range");

  // the first of two characters is shown with its partner behind it
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (cnt_r == 2'd2 && !out_tuser && slot1_r.last))
    else $error("two-character result out of order");

  // a result is never written over one still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && emit) |->
      (({1'b0, cnt_r} + (res_map.two ? 3'd2 : 3'd1)) <= (3'd2 + {2'b00, out_fire})))
    else $error("result register overwritten");

  // end of text always returns the decoder to idle
  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_eot_r) |=> (left_r == 3'd0 && accum_r == '0))
    else $error("decoder not idle after end of text");
`endif

endmodule

// ===== tb/stripper_checker.sv =====
// ----------------------------------------------------------------------------
// stripper_checker
// Watches the byte, character and fallback register channels of the accent
// stripper, predicts the characters each accepted byte produces and compares
// every accepted character field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module stripper_checker
  import u8l1s_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] in_byte
  input  logic              in_tlast,   // end_of_text
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [7:0]        out_tdata,  // [6:0] out_char, [7] zero
  input  logic              out_tlast,  // last_of_run
  input  logic              out_tuser,  // text_done
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CHAR_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Latin-1 0xC0..0xFF stripped of accents, 0xC0 in the top byte
  localparam logic [8*64-1:0] ACCENT_STRIP =
    "AAAAAAECEEEEIIIIDNOOOOOxOUUUUYPsaaaaaaeceeeeiiiidnooooo/ouuuuypy";

  // Latin-1 letters that become two ASCII letters
  localparam logic [7:0] CP_AE_UC    = 8'hC6;
  localparam logic [7:0] CP_ETH_UC   = 8'hD0;
  localparam logic [7:0] CP_THORN_UC = 8'hDE;
  localparam logic [7:0] CP_SHARP_S  = 8'hDF;
  localparam logic [7:0] CP_AE_LC    = 8'hE6;
  localparam logic [7:0] CP_ETH_LC   = 8'hF0;
  localparam logic [7:0] CP_THORN_LC = 8'hFE;

  // Only the first mismatches are printed; all are counted
  localparam int PRINT_LIMIT = 40;

  res_t                char_q[$];
  logic [ACCUM_W-1:0]  code_acc;
  logic [LEFT_W-1:0]   follow_left;
  logic [CHAR_W-1:0]   fallback;
  int                  result_idx;

  task automatic report_mismatch(input string field, input int want, input int got);
    fail_count++;
    if (fail_count <= PRINT_LIMIT)
      $display("%0t: character %0d: %s expected 0x%0h got 0x%0h",
               $realtime, result_idx, field, want, got);
  endtask

  // Queue one expected character behind the others
  task automatic queue_char(input res_t r);
    char_q = {char_q, r};
  endtask

  // Decode one byte; a completed (or cut-off) code point queues its characters
  task automatic predict_chars(input logic [7:0] b, input logic eot);
    logic [CHAR_W-1:0] first;
    logic [CHAR_W-1:0] second;
    logic [7:0]        tbl;
    logic              pair;
    res_t              r;
    if (follow_left != 0) begin
      // following bytes are not checked: any byte adds its low six bits
      code_acc    = {code_acc[ACCUM_W-7:0], b[5:0]};
      follow_left = follow_left - 1'b1;
    end else begin
      casez (b)
        8'b1111_11??: begin follow_left = 3'd5; code_acc = ACCUM_W'(b & 8'h01); end
        8'b1111_10??: begin follow_left = 3'd4; code_acc = ACCUM_W'(b & 8'h03); end
        8'b1111_0???: begin follow_left = 3'd3; code_acc = ACCUM_W'(b & 8'h07); end
        8'b1110_????: begin follow_left = 3'd2; code_acc = ACCUM_W'(b & 8'h0F); end
        8'b110?_????: begin follow_left = 3'd1; code_acc = ACCUM_W'(b & 8'h1F); end
        // ASCII and lone continuation bytes stand for themselves
        default:      begin follow_left = 3'd0; code_acc = ACCUM_W'(b);         end
      endcase
    end

    // end of text inside a sequence flushes the partial value
    if (follow_left == 0 || eot) begin
      pair   = 1'b0;
      second = '0;
      if (code_acc < 31'h80) begin
        first = code_acc[CHAR_W-1:0];
      end else if (code_acc >= 31'hC0 && code_acc <= 31'hFF) begin
        tbl   = ACCENT_STRIP[8*(63 - int'(code_acc[5:0])) +: 8];
        first = tbl[CHAR_W-1:0];
        case (code_acc[7:0])
          CP_AE_UC: begin
            first = CHAR_W'("A"); second = CHAR_W'("E"); pair = 1'b1;
          end
          CP_ETH_UC, CP_THORN_UC: begin
            first = CHAR_W'("T"); second = CHAR_W'("H"); pair = 1'b1;
          end
          CP_SHARP_S: begin
            first = CHAR_W'("s"); second = CHAR_W'("s"); pair = 1'b1;
          end
          CP_AE_LC: begin
            first = CHAR_W'("a"); second = CHAR_W'("e"); pair = 1'b1;
          end
          CP_ETH_LC, CP_THORN_LC: begin
            first = CHAR_W'("t"); second = CHAR_W'("h"); pair = 1'b1;
          end
          default: pair = 1'b0;
        endcase
      end else begin
        first = fallback;
      end

      if (pair) begin
        r.ch = first;  r.last = 1'b0; r.done = 1'b0;
        queue_char(r);
        r.ch = second; r.last = 1'b1; r.done = eot;
        queue_char(r);
      end else begin
        r.ch = first;  r.last = 1'b1; r.done = eot;
        queue_char(r);
      end
      code_acc    = '0;
      follow_left = '0;
    end
  endtask

  // Result transfers are checked before this edge's byte is predicted
  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      char_q.delete();
      code_acc    = '0;
      follow_left = '0;
      fallback    = FALLBACK_RESET;
      result_idx  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (char_q.size() == 0) begin
          report_mismatch("unexpected character", 0, out_tdata);
        end else begin
          want = char_q.pop_front();
          if (out_tdata[CHAR_W-1:0] !== want.ch)
            report_mismatch("out_char", want.ch, out_tdata[CHAR_W-1:0]);
          if (out_tdata[7] !== 1'b0)
            report_mismatch("tdata pad bit", 0, out_tdata[7]);
          if (out_tlast !== want.last)
            report_mismatch("last_of_run", want.last, out_tlast);
          if (out_tuser !== want.done)
            report_mismatch("text_done", want.done, out_tuser);
        end
        result_idx++;
      end
      if (cfg_valid && cfg_ready)
        fallback = cfg_data;
      if (in_tvalid && in_tready)
        predict_chars(in_tdata, in_tlast);
    end
    pending_count <= char_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the UTF-8 to ASCII accent stripper.
// ----------------------------------------------------------------------------
// Sends a directed set of bytes (ASCII limits, lone continuation bytes,
// two-letter Latin-1 codes, a six-byte sequence, unchecked following bytes,
// texts cut inside a sequence), then mostly well-formed random code points
// mixed with noise, under three fallback settings and three idling mixes.
// A long output hold-off backs the block up into its input. The checker
// beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb
  import u8l1s_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 360;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [CHAR_W-1:0] cfg_data   = '0;

  int   fail_count;
  int   pending_count;
  int   cycle_count  = 0;
  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  int   bytes_sent   = 0;
  int   hold_left    = 0;
  logic hold_req     = 1'b0;
  logic hold_ack     = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  utf8_latin1_accent_stripper_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  stripper_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // One byte transfer; valid stays high for a back-to-back byte
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sender pause until every predicted character has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // a byte that completes nothing may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fallback(input logic [CHAR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random code point: mostly well-formed, some noise and cut-off texts
  task automatic send_code_point();
    logic [7:0] seq [6];
    int         kind;
    int         extra;
    int         stop;
    logic       eot;
    kind  = $urandom_range(99);
    eot   = ($urandom_range(11) == 0);
    extra = 0;
    if (kind < 30) begin
      seq[0] = 8'($urandom_range(127));
    end else if (kind < 58) begin
      // Latin-1 letters
      seq[0] = 8'hC3;
      extra  = 1;
    end else if (kind < 66) begin
      // 0x80..0xBF as two bytes: not mapped
      seq[0] = 8'hC2;
      extra  = 1;
    end else if (kind < 82) begin
      extra = $urandom_range(1, 5);
      case (extra)
        1:       seq[0] = 8'hC0 | 8'($urandom_range(31));
        2:       seq[0] = 8'hE0 | 8'($urandom_range(15));
        3:       seq[0] = 8'hF0 | 8'($urandom_range(7));
        4:       seq[0] = 8'hF8 | 8'($urandom_range(3));
        default: seq[0] = 8'hFC | 8'($urandom_range(3));
      endcase
    end else if (kind < 90) begin
      seq[0] = 8'h80 | 8'($urandom_range(63));
    end else begin
      // raw noise, may open a sequence that swallows following bytes
      seq[0] = 8'($urandom_range(255));
    end
    for (int k = 1; k <= extra; k++)
      seq[k] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                        : 8'h80 | 8'($urandom_range(63));
    stop = extra;
    if (extra > 0 && $urandom_range(19) == 0) begin
      stop = $urandom_range(extra - 1);
      eot  = 1'b1;
    end
    for (int k = 0; k <= stop; k++)
      send_byte(seq[k], (k == stop) ? eot : 1'b0);
  endtask

  // Stimulus
  initial begin
    int target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, fallback at its reset value
    tx_idle_pct = 12;
    rx_idle_pct <= 87;
    send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);                // ASCII limits
    send_byte(8'h80, 1'b0); send_byte(8'hBF, 1'b0);                // lone continuation
    send_byte(8'hC3, 1'b0); send_byte(8'h86, 1'b0);                // AE
    send_byte(8'hC3, 1'b0); send_byte(8'hBF, 1'b0);                // y, table end
    send_byte(8'hC3, 1'b0); send_byte(8'h80, 1'b0);                // A, table start
    send_byte(8'hC3, 1'b0); send_byte(8'h9F, 1'b1);                // ss ending a text
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);                                        // euro: fallback
    send_byte(8'hC3, 1'b0); send_byte(8'hC5, 1'b0);                // lead as follower
    send_byte(8'hFF, 1'b0);                                        // widest sequence
    repeat (5) send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b1);                // cut short
    send_byte(8'hC3, 1'b1);                                        // cut at the lead
    wait_drained();

    // Random, fallback at zero, receiver mostly stalled
    write_fallback('0);
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) send_code_point();
    wait_drained();

    // Random, fallback at its top, sender mostly idle
    write_fallback('1);
    tx_idle_pct = 87;
    rx_idle_pct <= 12;
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) send_code_point();
    wait_drained();

    // No idling; a long hold-off first backs the block up
    write_fallback(CHAR_W'($urandom_range(127)));
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req <= ~hold_req;
    for (int i = 0; i < 40; i++) send_byte(8'(8'h61 + i % 26), 1'b0);
    wait_drained();
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) begin
      send_code_point();
      if (bytes_sent % 120 == 0) wait_drained();
    end
    wait_drained();

    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
